// ===== hw/rtl/svpr_pkg.sv =====
// svpr_pkg: shared types and constants for the servo packet receiver queue.
// Used by svpr_ctrl, svpr_datapath and servo_packet_receiver_queue; no dependencies.
`timescale 1ns / 1ps

package svpr_pkg;

  // opcode field values
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_POP     = 1'b1;

  // configuration register indexes
  localparam logic REG_HEADER_FIRST  = 1'b0;
  localparam logic REG_HEADER_SECOND = 1'b1;

  localparam logic [7:0] HEADER_RESET = 8'hFF;
  localparam int         MIN_LENGTH   = 2;

  // controller -> datapath
  typedef struct packed {
    logic rx_id;       // capture id byte
    logic rx_len;      // capture length byte
    logic rx_data;     // store one data byte
    logic copy_start;  // begin moving assembled payload into the ring
    logic copy_step;   // read one assembled byte
    logic commit;      // finish the copy, advance write slot
    logic pop_start;   // latch oldest slot, advance read slot
    logic pop_step;    // read one payload byte of the popped slot
    logic pop_empty;   // emit the single empty-ring result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hdr1_hit;
    logic hdr2_hit;
    logic len_ok;
    logic data_last;
    logic csum_ok;
    logic ring_full;
    logic ring_empty;
    logic copy_end;
    logic pop_end;
  } sts_t;

endpackage

// ===== hw/rtl/svpr_ctrl.sv =====
// svpr_ctrl: parser phase and sequencer state machines.
// Depends on svpr_pkg; drives svpr_datapath through cmd_t, reads sts_t.
`timescale 1ns / 1ps

module svpr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            opcode,
  input  svpr_pkg::sts_t  sts,
  output svpr_pkg::cmd_t  cmd,
  output logic            busy
);
  import svpr_pkg::*;

  typedef enum logic [2:0] {
    P_HEAD1, P_HEAD2, P_ID, P_LEN, P_DATA
  } phase_t;

  typedef enum logic [1:0] {
    S_IDLE, S_COPY, S_DRAIN, S_POP
  } seq_t;

  phase_t phase, phase_next;
  seq_t   seq, seq_next;
  logic   go;

  assign busy = (seq != S_IDLE);
  assign go   = start && (seq == S_IDLE);

  always_comb begin
    cmd        = '0;
    phase_next = phase;
    seq_next   = seq;
    case (seq)
      S_IDLE: begin
        if (go && (opcode == OP_POP)) begin
          if (sts.ring_empty) begin
            cmd.pop_empty = 1'b1;
          end else begin
            cmd.pop_start = 1'b1;
            seq_next      = S_POP;
          end
        end else if (go) begin
          case (phase)
            P_HEAD2: begin
              phase_next = sts.hdr2_hit ? P_ID : P_HEAD1;
            end
            P_ID: begin
              cmd.rx_id  = 1'b1;
              phase_next = P_LEN;
            end
            P_LEN: begin
              cmd.rx_len = 1'b1;
              phase_next = sts.len_ok ? P_DATA : P_HEAD1;
            end
            P_DATA: begin
              cmd.rx_data = 1'b1;
              if (sts.data_last) begin
                phase_next = P_HEAD1;
                if (sts.csum_ok && !sts.ring_full) begin
                  cmd.copy_start = 1'b1;
                  seq_next       = S_COPY;
                end
              end
            end
            default: begin
              phase_next = sts.hdr1_hit ? P_HEAD2 : P_HEAD1;
            end
          endcase
        end
      end
      S_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_end) seq_next = S_DRAIN;
      end
      S_DRAIN: begin
        cmd.commit = 1'b1;
        seq_next   = S_IDLE;
      end
      S_POP: begin
        cmd.pop_step = 1'b1;
        if (sts.pop_end) seq_next = S_IDLE;
      end
      default: begin
        seq_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_HEAD1;
      seq   <= S_IDLE;
    end else begin
      phase <= phase_next;
      seq   <= seq_next;
    end
  end

endmodule

// ===== hw/rtl/svpr_datapath.sv =====
// svpr_datapath: header registers, packet assembly memory, running checksum,
// slot ring memory and result registers. Depends on svpr_pkg; driven by svpr_ctrl.
`timescale 1ns / 1ps

module svpr_datapath #(
  parameter int DATA_MAX    = 32,
  parameter int FRAME_SLOTS = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      rx_byte,
  input  logic            cfg_we,
  input  logic            cfg_index,
  input  logic [7:0]      cfg_data,
  input  svpr_pkg::cmd_t  cmd,
  output svpr_pkg::sts_t  sts,
  output logic            out_strobe,
  output logic            packet_valid,
  output logic [7:0]      packet_id,
  output logic [4:0]      packet_length,
  output logic [7:0]      payload_byte,
  output logic            last_byte,
  output logic [2:0]      packets_waiting
);
  import svpr_pkg::*;

  localparam int W      = $clog2(DATA_MAX);
  localparam int SLOT_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W  = $clog2(FRAME_SLOTS + 1);
  localparam int AW     = SLOT_W + W;

  logic [7:0] header_first, header_second;

  // packet being parsed
  logic [7:0]   cur_id;
  logic [W-1:0] cur_len;
  logic [W-1:0] byte_cnt;
  logic [W-1:0] cnt_inc;
  logic [7:0]   sum;

  logic [7:0] asm_mem [DATA_MAX];
  logic [7:0] asm_q;

  // ring
  logic [7:0]        smem [1 << AW];
  logic [7:0]        smem_q;
  logic [7:0]        slot_ids  [FRAME_SLOTS];
  logic [W-1:0]      slot_lens [FRAME_SLOTS];
  logic [SLOT_W-1:0] write_slot, read_slot, rd_slot_l;
  logic [CNT_W-1:0]  used;

  // copy pipeline
  logic [W-1:0] cp_idx, wr_idx;
  logic         wr_v;

  // pop
  logic [W-1:0]     pop_idx;
  logic [7:0]       out_id;
  logic [W-1:0]     out_len;
  logic [CNT_W-1:0] waiting;
  logic             o_v, o_pv, o_last;
  logic [31:0]      len_ext, wait_ext;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(FRAME_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  assign cnt_inc = byte_cnt + W'(1);

  assign sts.hdr1_hit   = (rx_byte == header_first);
  assign sts.hdr2_hit   = (rx_byte == header_second);
  assign sts.len_ok     = (rx_byte >= 8'(MIN_LENGTH)) && (rx_byte < 8'(DATA_MAX));
  assign sts.data_last  = (cnt_inc == cur_len);
  assign sts.csum_ok    = (~sum == rx_byte);
  assign sts.ring_full  = (used == CNT_W'(FRAME_SLOTS));
  assign sts.ring_empty = (used == '0);
  // payload count is length - 1, so the final index is length - 2
  assign sts.copy_end   = (cp_idx == cur_len - W'(MIN_LENGTH));
  assign sts.pop_end    = (pop_idx == out_len - W'(MIN_LENGTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_RESET;
      header_second <= HEADER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_FIRST:  header_first  <= cfg_data;
        REG_HEADER_SECOND: header_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // parse registers and assembly memory
  always_ff @(posedge clk) begin
    if (cmd.rx_id) begin
      cur_id <= rx_byte;
      sum    <= rx_byte;
    end
    if (cmd.rx_len) begin
      cur_len  <= rx_byte[W-1:0];
      sum      <= sum + rx_byte;
      byte_cnt <= '0;
    end
    if (cmd.rx_data) begin
      asm_mem[byte_cnt] <= rx_byte;
      byte_cnt          <= cnt_inc;
      sum               <= sum + rx_byte;
    end
    asm_q <= asm_mem[cp_idx];
    if (cmd.copy_start) cp_idx <= '0;
    if (cmd.copy_step)  cp_idx <= cp_idx + W'(1);
    wr_idx <= cp_idx;
  end

  // slot payload memory
  always_ff @(posedge clk) begin
    if (wr_v) smem[{write_slot, wr_idx}] <= asm_q;
    smem_q <= smem[{rd_slot_l, pop_idx}];
  end

  // slot headers and pop registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_ids[write_slot]  <= cur_id;
      slot_lens[write_slot] <= cur_len;
    end
    if (cmd.pop_start) begin
      out_id    <= slot_ids[read_slot];
      out_len   <= slot_lens[read_slot];
      rd_slot_l <= read_slot;
      waiting   <= used - CNT_W'(1);
      pop_idx   <= '0;
    end
    if (cmd.pop_step) pop_idx <= pop_idx + W'(1);
    o_pv   <= cmd.pop_step;
    o_last <= cmd.pop_empty || (cmd.pop_step && sts.pop_end);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      read_slot  <= '0;
      used       <= '0;
      wr_v       <= 1'b0;
      o_v        <= 1'b0;
    end else begin
      wr_v <= cmd.copy_step;
      o_v  <= cmd.pop_step || cmd.pop_empty;
      if (cmd.commit) begin
        write_slot <= slot_inc(write_slot);
        used       <= used + CNT_W'(1);
      end else if (cmd.pop_start) begin
        read_slot <= slot_inc(read_slot);
        used      <= used - CNT_W'(1);
      end
    end
  end

  assign len_ext  = 32'(out_len);
  assign wait_ext = 32'(waiting);

  assign out_strobe      = o_v;
  assign packet_valid    = o_pv;
  assign last_byte       = o_last;
  assign packet_id       = o_pv ? out_id : '0;
  assign packet_length   = o_pv ? len_ext[4:0] : '0;
  assign payload_byte    = o_pv ? smem_q : '0;
  assign packets_waiting = o_pv ? wait_ext[2:0] : '0;

endmodule

// ===== hw/rtl/servo_packet_receiver_queue.sv =====
// servo_packet_receiver_queue: top level of the serial packet receiver with packet ring.
// Depends on svpr_pkg, svpr_ctrl and svpr_datapath.
`timescale 1ns / 1ps
//
//  channel  | signals                                         | handshake
//  ---------+-------------------------------------------------+---------------------------
//  command  | start, busy, opcode, rx_byte                    | taken when start & !busy
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data       | taken when valid & ready
//  result   | out_strobe, packet_valid, packet_id,            | one-cycle strobe, no stall
//           | packet_length, payload_byte, last_byte,         |
//           | packets_waiting                                 |
//
//  The checksum byte of a good packet that fits the ring starts a copy of its payload
//  into the ring: one assembled byte per cycle, then one write-back. A pop of a stored
//  packet first latches the oldest slot, then reads one payload byte per cycle off the
//  ring memory. An empty pop only emits the empty-ring result. Results appear in the
//  cycle after their read. Reset (rst, synchronous) empties the ring and restarts
//  the header hunt without clearing memories. The receiver cannot stall results.

module servo_packet_receiver_queue #(
  parameter int DATA_MAX    = 32,
  parameter int FRAME_SLOTS = 4
) (
  input  logic       clk,
  input  logic       rst,
  // command transaction
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  // configuration write transaction
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  // result transaction
  output logic       out_strobe,
  output logic       packet_valid,
  output logic [7:0] packet_id,
  output logic [4:0] packet_length,
  output logic [7:0] payload_byte,
  output logic       last_byte,
  output logic [2:0] packets_waiting
);
  import svpr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // header registers are writable at any time
  assign cfg_ready = 1'b1;

  svpr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  svpr_datapath #(
    .DATA_MAX    (DATA_MAX),
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .rx_byte         (rx_byte),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .out_strobe      (out_strobe),
    .packet_valid    (packet_valid),
    .packet_id       (packet_id),
    .packet_length   (packet_length),
    .payload_byte    (payload_byte),
    .last_byte       (last_byte),
    .packets_waiting (packets_waiting)
  );

  // a packet is only committed into a ring with room for it
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !sts.ring_full)
    else $error("commit into a full ring");

  // a pop only latches a slot when one is stored
  a_pop_stored: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_start |-> !sts.ring_empty)
    else $error("pop started on an empty ring");

  // an empty-ring result is always the only result of its pop
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_strobe && !packet_valid) |-> last_byte)
    else $error("empty result without last marker");

  // busy only rises after a command transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

endmodule
